// ===== rtl/fwm_pkg.sv =====
// Shared types and codes for the first-in first-out queue with running minimum.
package fwm_pkg;

    localparam int VALUE_W = 32;
    localparam int OPCODE_W = 3;
    localparam int STATUS_W = 2;
    localparam int OCC_W = 11;

    localparam logic [OPCODE_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_POP   = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_PEEK  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_OCC   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_MIN   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0]       opcode;
        logic signed [VALUE_W-1:0] push_value;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] result_value;
        logic [OCC_W-1:0]          occupancy;
    } rsp_t;

    // Contents of one storage cell: its entry and the minimum of it and every newer entry.
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic signed [VALUE_W-1:0] smin;
    } cell_t;

    // Control broadcast to every cell.
    typedef struct packed {
        logic                      clear;
        logic                      shift;
        logic                      push;
        logic signed [VALUE_W-1:0] value;
    } cell_ctl_t;

endpackage

// ===== rtl/fwm_cell.sv =====
// One storage cell of the queue chain, holding an entry and its suffix minimum.
module fwm_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  fwm_pkg::cell_ctl_t ctl,
    input  logic              prev_valid,
    input  fwm_pkg::cell_t    next_cell,
    output fwm_pkg::cell_t    contents
);

    logic                              valid_reg;
    logic signed [fwm_pkg::VALUE_W-1:0] value_reg;
    logic signed [fwm_pkg::VALUE_W-1:0] smin_reg;
    logic                              tail_load;

    // The first empty cell behind the last occupied one takes a pushed value.
    assign tail_load = ctl.push && !valid_reg && prev_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            valid_reg <= next_cell.valid;
        end
        else if (tail_load)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            value_reg <= next_cell.value;
            smin_reg  <= next_cell.smin;
        end
        else if (tail_load)
        begin
            value_reg <= ctl.value;
            smin_reg  <= ctl.value;
        end
        else if (ctl.push && valid_reg && (ctl.value < smin_reg))
        begin
            smin_reg <= ctl.value;
        end
    end

    assign contents = {valid_reg, value_reg, smin_reg};

endmodule

// ===== rtl/fifo_with_minimum.sv =====
// Latency: a result appears on rsp, marked by done, in the cycle after start is taken.
// Throughput: one command a cycle; every cell updates in the same cycle, so busy stays low.
// The oldest entry sits in cell 0; a pop shifts the whole chain one cell towards it.
// Reset clears the cell valid bits, the occupancy count and the output strobe at once;
// the stored values need no clearing pass because only valid cells are ever read.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module fifo_with_minimum
#(
    parameter int QUEUE_DEPTH = 1024
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  fwm_pkg::cmd_t cmd,
    output logic          done,
    output fwm_pkg::rsp_t rsp
);

    // The count must hold the depth itself, hence one value more than the cell index.
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int OccWidth = fwm_pkg::OCC_W;

    fwm_pkg::cell_t     cells [QUEUE_DEPTH];
    fwm_pkg::cell_ctl_t ctl;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    fwm_pkg::rsp_t    rsp_reg;
    fwm_pkg::rsp_t    rsp_next;
    logic             accept;
    logic             is_empty;
    logic             is_full;

    // Every command completes in the cycle it is taken, so the block never holds off start.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));

    // Command decode. The cells are told what to do through a single broadcast
    // control word; the cell chain itself keeps the minimum of every suffix, so
    // cell 0 always carries the minimum of the whole contents.
    always_comb
    begin
        ctl                   = '0;
        ctl.value             = cmd.push_value;
        count_next            = count_reg;
        rsp_next.status       = fwm_pkg::ST_OK;
        rsp_next.result_value = '0;
        if (accept)
        begin
            unique case (cmd.opcode)
                fwm_pkg::OP_PUSH:
                begin
                    if (is_full)
                    begin
                        rsp_next.status = fwm_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctl.push   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                fwm_pkg::OP_POP:
                begin
                    if (is_empty)
                    begin
                        rsp_next.status = fwm_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rsp_next.result_value = cells[0].value;
                        ctl.shift             = 1'b1;
                        count_next            = count_reg - CNT_W'(1);
                    end
                end
                fwm_pkg::OP_PEEK:
                begin
                    if (is_empty)
                    begin
                        rsp_next.status = fwm_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rsp_next.result_value = cells[0].value;
                    end
                end
                fwm_pkg::OP_CLEAR:
                begin
                    ctl.clear  = 1'b1;
                    count_next = '0;
                end
                fwm_pkg::OP_MIN:
                begin
                    if (is_empty)
                    begin
                        rsp_next.status = fwm_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rsp_next.result_value = cells[0].smin;
                    end
                end
                default:
                begin
                    // Occupancy reads and unused codes change nothing.
                end
            endcase
        end
        rsp_next.occupancy = OccWidth'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // The chain of cells: each takes its newer neighbour's contents on a pop and
    // looks at its older neighbour's valid bit to find the tail on a push.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic           prev_valid;
        fwm_pkg::cell_t next_cell;

        if (i == 0)
        begin : g_head
            assign prev_valid = 1'b1;
        end
        else
        begin : g_body
            assign prev_valid = cells[i-1].valid;
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign next_cell = '0;
        end
        else
        begin : g_inner
            assign next_cell = cells[i+1];
        end

        fwm_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .prev_valid (prev_valid),
            .next_cell  (next_cell),
            .contents   (cells[i])
        );
    end

endmodule
